### rtl/fwrm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwrm_pkg
// Shared types, constants and index helpers for the FIFO with running maximum.
// ----------------------------------------------------------------------------
package fwrm_pkg;

    localparam int DEPTH    = 16;
    localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_CMP,
        S_PUSH_WR,
        S_POP_UPD,
        S_MAX_RD,
        S_FINISH
    } state_t;

    // circular index: base + off, folded once into 0 .. DEPTH-1
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(DEPTH))
        begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/fwrm_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwrm_in_if
// Operation channel: push a value or pop the oldest one.
// ----------------------------------------------------------------------------
interface fwrm_in_if
    import fwrm_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [VAL_W-1:0] push_value;

    modport source (output valid, output kind, output push_value, input ready);
    modport sink   (input valid, input kind, input push_value, output ready);
endinterface
`default_nettype wire

### rtl/fwrm_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwrm_out_if
// Result channel: one item per operation with value, status and maximum.
// ----------------------------------------------------------------------------
interface fwrm_out_if
    import fwrm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [VAL_W-1:0]    popped_value;
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    current_max;
    logic                max_valid;
    logic [FILL_W-1:0]   fill_level;

    modport source (output valid, output popped_value, output status,
                    output current_max, output max_valid, output fill_level,
                    input ready);
    modport sink   (input valid, input popped_value, input status,
                    input current_max, input max_valid, input fill_level,
                    output ready);
endinterface
`default_nettype wire

### rtl/fifo_with_running_max_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_with_running_max_top
// FIFO of signed 32-bit values that reports its largest held value per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (sink)   : one item per operation; kind 0 pushes push_value,
//                     kind 1 pops the oldest value.
//   out_ch (source) : exactly one result item per operation item, carrying
//                     the popped value, status (ok / pop from empty / push
//                     to full dropped), the running maximum and fill level.
// Timing:
//   A pop runs the pop update, maxima read and finish steps; a push runs
//   k tail compares in the maxima store, the write, maxima read and finish,
//   where k is none when the store is empty, else one per discarded entry
//   plus one unless every entry is discarded. A pop from an empty queue or
//   a dropped push runs only maxima read and finish. Each value leaves the
//   maxima store at most once, so k averages at most two; the sequencer
//   walks the single compare unit and the one read port of each store. The
//   result appears in the same cycle that the next item can be taken.
// Reset: rst_n clears the counts and heads, so the queue is empty at once;
//   the stores are not cleared, nothing unwritten is ever shown.
// Stalls: a result waits in the output register while ready is low; the
//   next item is still accepted and worked on, and holds in its final step
//   until the output register is free.
// ----------------------------------------------------------------------------
module fifo_with_running_max_top
    import fwrm_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    fwrm_in_if.sink     in_ch,
    fwrm_out_if.source  out_ch
);

    // sequencer and queue pointers
    state_t           state_reg,  state_next;
    logic [PTR_W-1:0] fhead_reg,  fhead_next;
    logic [CNT_W-1:0] fcount_reg, fcount_next;
    logic [PTR_W-1:0] mhead_reg,  mhead_next;
    logic [CNT_W-1:0] mcount_reg, mcount_next;

    // current item
    logic             kind_reg,   kind_next;
    logic [VAL_W-1:0] value_reg,  value_next;
    logic [VAL_W-1:0] popped_reg, popped_next;
    status_t          st_reg,     st_next;

    // output register
    logic              ovalid_reg,  ovalid_next;
    logic [VAL_W-1:0]  opop_reg,    opop_next;
    status_t           ostatus_reg, ostatus_next;
    logic [VAL_W-1:0]  omax_reg,    omax_next;
    logic              omvalid_reg, omvalid_next;
    logic [FILL_W-1:0] ofill_reg,   ofill_next;

    // stores, one write and one registered read port each
    logic [VAL_W-1:0] fifo_mem [DEPTH];
    logic [VAL_W-1:0] max_mem  [DEPTH];
    logic             fifo_re, fifo_we, max_re, max_we;
    logic [PTR_W-1:0] fifo_rd_addr, fifo_wr_addr, max_rd_addr, max_wr_addr;
    logic [VAL_W-1:0] fifo_rd_reg, max_rd_reg;

    // shared compare unit
    logic [VAL_W-1:0] cmp_b;
    logic             cmp_lt, cmp_eq;

    logic accept;
    logic out_free;
    logic q_empty, q_full, m_empty;

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !ovalid_reg || out_ch.ready;
    assign q_empty  = (fcount_reg == '0);
    assign q_full   = (fcount_reg == CNT_W'(DEPTH));
    assign m_empty  = (mcount_reg == '0);

    // maxima entry against the new value on a push, against the popped value on a pop
    assign cmp_b  = (state_reg == S_POP_UPD) ? fifo_rd_reg : value_reg;
    assign cmp_lt = $signed(max_rd_reg) < $signed(cmp_b);
    assign cmp_eq = (max_rd_reg == cmp_b);

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = ovalid_reg;
    assign out_ch.popped_value = opop_reg;
    assign out_ch.status       = ostatus_reg;
    assign out_ch.current_max  = omax_reg;
    assign out_ch.max_valid    = omvalid_reg;
    assign out_ch.fill_level   = ofill_reg;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.kind == KIND_POP)
                    begin
                        state_next = q_empty ? S_MAX_RD : S_POP_UPD;
                    end
                    else if (q_full)
                    begin
                        state_next = S_MAX_RD;
                    end
                    else
                    begin
                        state_next = m_empty ? S_PUSH_WR : S_PUSH_CMP;
                    end
                end
            end
            S_PUSH_CMP:
            begin
                if (!(cmp_lt && (mcount_reg != CNT_W'(1))))
                begin
                    state_next = S_PUSH_WR;
                end
            end
            S_PUSH_WR: state_next = S_MAX_RD;
            S_POP_UPD: state_next = S_MAX_RD;
            S_MAX_RD:  state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and store control
    // ------------------------------------------------------------------
    always_comb
    begin
        fhead_next   = fhead_reg;
        fcount_next  = fcount_reg;
        mhead_next   = mhead_reg;
        mcount_next  = mcount_reg;
        kind_next    = kind_reg;
        value_next   = value_reg;
        popped_next  = popped_reg;
        st_next      = st_reg;
        ovalid_next  = ovalid_reg;
        opop_next    = opop_reg;
        ostatus_next = ostatus_reg;
        omax_next    = omax_reg;
        omvalid_next = omvalid_reg;
        ofill_next   = ofill_reg;
        fifo_re      = 1'b0;
        fifo_we      = 1'b0;
        max_re       = 1'b0;
        max_we       = 1'b0;
        fifo_rd_addr = fhead_reg;
        fifo_wr_addr = wrap_add(fhead_reg, fcount_reg);
        max_rd_addr  = mhead_reg;
        max_wr_addr  = wrap_add(mhead_reg, mcount_reg);

        // drop the result once the receiver takes it
        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next   = in_ch.kind;
                    value_next  = in_ch.push_value;
                    popped_next = '0;
                    st_next     = ST_OK;
                    if (in_ch.kind == KIND_POP)
                    begin
                        if (q_empty)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else
                        begin
                            fifo_re     = 1'b1;
                            max_re      = 1'b1;
                            max_rd_addr = mhead_reg;
                        end
                    end
                    else if (q_full)
                    begin
                        st_next = ST_FULL;
                    end
                    else if (!m_empty)
                    begin
                        max_re      = 1'b1;
                        max_rd_addr = wrap_add(mhead_reg, mcount_reg - CNT_W'(1));
                    end
                end
            end
            S_PUSH_CMP:
            begin
                // discard a tail entry strictly below the new value, fetch the next
                if (cmp_lt)
                begin
                    mcount_next = mcount_reg - CNT_W'(1);
                    if (mcount_reg != CNT_W'(1))
                    begin
                        max_re      = 1'b1;
                        max_rd_addr = wrap_add(mhead_reg, mcount_reg - CNT_W'(2));
                    end
                end
            end
            S_PUSH_WR:
            begin
                fifo_we     = 1'b1;
                max_we      = 1'b1;
                fcount_next = fcount_reg + CNT_W'(1);
                mcount_next = mcount_reg + CNT_W'(1);
            end
            S_POP_UPD:
            begin
                popped_next = fifo_rd_reg;
                if (!m_empty && cmp_eq)
                begin
                    mhead_next  = wrap_add(mhead_reg, CNT_W'(1));
                    mcount_next = mcount_reg - CNT_W'(1);
                end
                fhead_next  = wrap_add(fhead_reg, CNT_W'(1));
                fcount_next = fcount_reg - CNT_W'(1);
            end
            S_MAX_RD:
            begin
                max_re      = 1'b1;
                max_rd_addr = mhead_reg;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    opop_next    = popped_reg;
                    ostatus_next = st_reg;
                    omvalid_next = !q_empty && !m_empty;
                    omax_next    = (!q_empty && !m_empty) ? max_rd_reg : '0;
                    ofill_next   = FILL_W'(fcount_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fhead_reg  <= '0;
            fcount_reg <= '0;
            mhead_reg  <= '0;
            mcount_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fhead_reg  <= fhead_next;
            fcount_reg <= fcount_next;
            mhead_reg  <= mhead_next;
            mcount_reg <= mcount_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        value_reg   <= value_next;
        popped_reg  <= popped_next;
        st_reg      <= st_next;
        opop_reg    <= opop_next;
        ostatus_reg <= ostatus_next;
        omax_reg    <= omax_next;
        omvalid_reg <= omvalid_next;
        ofill_reg   <= ofill_next;
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[fifo_wr_addr] <= value_reg;
        end
        if (fifo_re)
        begin
            fifo_rd_reg <= fifo_mem[fifo_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (max_we)
        begin
            max_mem[max_wr_addr] <= value_reg;
        end
        if (max_re)
        begin
            max_rd_reg <= max_mem[max_rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_max_le_fifo: assert property (@(posedge clk) disable iff (!rst_n)
        mcount_reg <= fcount_reg)
        else $error("maxima store holds more entries than the queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcount_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_full_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUSH_WR |-> !q_full && kind_reg == KIND_PUSH)
        else $error("store write on a full queue or a pop");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("sequencer idle straight after taking an item");

endmodule
`default_nettype wire
